// File: hdl/fpba_pkg.sv
package fpba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    // Fixed field widths of the items
    localparam int LOAD_IDX_W = 4;
    localparam int REQ_SIZE_W = 16;
    localparam int FIT_MODE_W = 2;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // Derived widths
    localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W   = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
    localparam int IDXX_W  = (IDX_W > LOAD_IDX_W) ? IDX_W : LOAD_IDX_W;
    localparam int SIZEX_W = (SIZE_BITS > REQ_SIZE_W) ? SIZE_BITS : REQ_SIZE_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 1'b1;

    // Placement policies; the unused code behaves as first fit
    localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

    // Item kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    typedef struct packed {
        logic                  req_type;
        logic [LOAD_IDX_W-1:0] load_index;
        logic [REQ_SIZE_W-1:0] req_size;
    } in_item_t;

    typedef struct packed {
        logic                  granted;
        logic [LOAD_IDX_W-1:0] chosen_index;
        logic [REQ_SIZE_W-1:0] free_left;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     addr;
        logic [SIZE_BITS-1:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic                 fits;
        logic                 better;
        logic [SIZE_BITS-1:0] diff;
    } unit_res_t;

endpackage

// File: hdl/fit_policy_block_allocator.sv
// Fit-policy block allocator. Keeps a table of free sizes, one per memory
// block, all zero after reset. A load item (req_type 0) writes one entry and
// returns it; an allocate item (req_type 1) searches the first active_blocks
// entries for one whose free size is at least req_size: first fit takes the
// lowest index, best fit the smallest fitting size, worst fit the largest,
// ties to the lower index. The request is subtracted from the chosen entry
// and the grant, index and remainder come back as one result item; with
// nothing fitting the result is all zero. An allocate item passes through
// the accept, scan, update and output states, testing the entries one at a
// time on the shared subtract/compare unit, which also forms the remainder
// at update; first fit stops after the first hit. A load item passes
// through the accept, load and output states. The input side is ready only
// when no item is in work; a finished result waits in the output register
// while the next item is taken. Write fit_mode and active_blocks only while
// the block is idle.
module fit_policy_block_allocator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  fpba_pkg::in_item_t               s_item,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output fpba_pkg::out_item_t              m_item
);
    import fpba_pkg::*;

    state_t state_reg, state_next;

    // configuration registers
    logic [FIT_MODE_W-1:0] fit_mode_reg;
    logic [ACTIVE_W-1:0]   active_reg;

    // item in work
    logic [IDXX_W-1:0]     lidx_reg,   lidx_next;
    logic [SIZE_BITS-1:0]  size_reg,   size_next;

    // scan state
    logic [CNT_W-1:0]      scan_reg,   scan_next;
    logic                  found_reg,  found_next;
    logic [IDX_W-1:0]      pick_reg,   pick_next;
    logic [SIZE_BITS-1:0]  best_reg,   best_next;

    // finished result waiting for the output register
    out_item_t             res_reg,    res_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg,  m_item_next;

    tbl_wr_t               tbl_wr;
    logic [SIZE_BITS-1:0]  rdata;
    logic [SIZE_BITS-1:0]  unit_value;
    unit_res_t             unit_res;

    logic [LIM_W-1:0]      act_ext, limit, scan_ext;
    logic                  scan_end;
    logic [SIZEX_W-1:0]    size_in_ext;
    logic [SIZEX_W-1:0]    left_ext;
    logic [IDXX_W-1:0]     pick_ext;

    fpba_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .raddr   (scan_reg[IDX_W-1:0]),
        .rdata   (rdata)
    );

    fpba_unit u_unit (
        .fit_mode (fit_mode_reg),
        .value    (unit_value),
        .size     (size_reg),
        .best     (best_reg),
        .res      (unit_res)
    );

    // Configuration writes; active_blocks above the table depth is clipped below
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= FIT_FIRST;
            active_reg   <= ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FIT_MODE: fit_mode_reg <= cfg_wdata[FIT_MODE_W-1:0];
                CFG_ACTIVE:   active_reg   <= cfg_wdata[ACTIVE_W-1:0];
                default:      ;
            endcase
        end
    end

    // Search limit: min(active_blocks, NUM_BLOCKS)
    assign act_ext  = LIM_W'(active_reg);
    assign limit    = (act_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : act_ext;
    assign scan_ext = LIM_W'(scan_reg);
    // first fit ends as soon as one entry fits
    assign scan_end = (scan_ext >= limit) ||
                      (found_reg && fit_mode_reg != FIT_BEST && fit_mode_reg != FIT_WORST);

    // The unit tests entries during the scan and forms the remainder at update
    assign unit_value = (state_reg == ST_UPDATE) ? best_reg : rdata;

    assign size_in_ext = SIZEX_W'(s_item.req_size);
    assign left_ext    = SIZEX_W'(unit_res.diff);
    assign pick_ext    = IDXX_W'(pick_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        lidx_reg   <= lidx_next;
        size_reg   <= size_next;
        scan_reg   <= scan_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    always_comb begin
        state_next   = state_reg;
        lidx_next    = lidx_reg;
        size_next    = size_reg;
        scan_next    = scan_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        tbl_wr       = '0;
        s_ready      = 1'b0;

        // drop the shown result once taken
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    lidx_next  = IDXX_W'(s_item.load_index);
                    size_next  = size_in_ext[SIZE_BITS-1:0];
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = (s_item.req_type == REQ_ALLOC) ? ST_SCAN : ST_LOAD;
                end
            end

            ST_LOAD: begin
                // ignore loads beyond the table
                if ((IDXX_W+1)'(lidx_reg) < (IDXX_W+1)'(NUM_BLOCKS)) begin
                    tbl_wr.en    = 1'b1;
                    tbl_wr.addr  = lidx_reg[IDX_W-1:0];
                    tbl_wr.data  = size_reg;
                    res_next.granted      = 1'b1;
                    res_next.chosen_index = lidx_reg[LOAD_IDX_W-1:0];
                    res_next.free_left    = REQ_SIZE_W'(size_reg);
                end else begin
                    res_next = '0;
                end
                state_next = ST_OUT;
            end

            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_UPDATE;
                end else begin
                    // take the entry if it fits and beats the current pick
                    if (unit_res.fits && (!found_reg || unit_res.better)) begin
                        found_next = 1'b1;
                        pick_next  = scan_reg[IDX_W-1:0];
                        best_next  = rdata;
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            ST_UPDATE: begin
                if (found_reg) begin
                    tbl_wr.en    = 1'b1;
                    tbl_wr.addr  = pick_reg;
                    tbl_wr.data  = unit_res.diff;
                    res_next.granted      = 1'b1;
                    res_next.chosen_index = pick_ext[LOAD_IDX_W-1:0];
                    res_next.free_left    = left_ext[REQ_SIZE_W-1:0];
                end else begin
                    res_next = '0;
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: hdl/fpba_table.sv
module fpba_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fpba_pkg::tbl_wr_t             wr,
    input  logic [fpba_pkg::IDX_W-1:0]    raddr,
    output logic [fpba_pkg::SIZE_BITS-1:0] rdata
);
    import fpba_pkg::*;

    logic [SIZE_BITS-1:0] free_reg [NUM_BLOCKS];

    // Free-size table: one write port, one read port; cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                free_reg[i] <= '0;
            end
        end else if (wr.en) begin
            free_reg[wr.addr] <= wr.data;
        end
    end

    assign rdata = free_reg[raddr];

endmodule

// File: hdl/fpba_unit.sv
module fpba_unit (
    input  logic [fpba_pkg::FIT_MODE_W-1:0] fit_mode,
    input  logic [fpba_pkg::SIZE_BITS-1:0]  value,
    input  logic [fpba_pkg::SIZE_BITS-1:0]  size,
    input  logic [fpba_pkg::SIZE_BITS-1:0]  best,
    output fpba_pkg::unit_res_t             res
);
    import fpba_pkg::*;

    logic [SIZE_BITS:0] sub;

    // One subtractor: no borrow means the value holds the request
    assign sub = {1'b0, value} - {1'b0, size};

    always_comb begin
        res.fits = ~sub[SIZE_BITS];
        res.diff = sub[SIZE_BITS-1:0];
        case (fit_mode)
            FIT_BEST:  res.better = (value < best);
            FIT_WORST: res.better = (value > best);
            default:   res.better = 1'b0;
        endcase
    end

endmodule

// File: dv/fit_policy_block_allocator_tb.sv
`timescale 1ns / 1ps

module fit_policy_block_allocator_tb;
    import fpba_pkg::*;

    // Spare policy code; the block treats it as first fit.
    localparam logic [FIT_MODE_W-1:0] FIT_UNUSED = 2'd3;

    localparam int RST_CYCLES    = 9;
    localparam int QUIET_LIMIT   = 4000;  // cycles with no item moving on either side
    localparam int SETTLE_CYCLES = 40;    // idle time after the last drain before the final check
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int MAX_GAP       = 30;
    localparam int MAX_REPORTS   = 10;

    // One line of the directed stimulus: either a register write or an item,
    // the latter optionally with its result spelled out by hand.
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_item_t              item;
        bit                    known;
        out_item_t             want;
    } step_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;

    // Local copy of the allocator: free-size table and both registers.
    logic [SIZE_BITS-1:0]  free_tab [NUM_BLOCKS];
    logic [FIT_MODE_W-1:0] mode_cur;
    logic [ACTIVE_W-1:0]   active_cur;

    out_item_t pending_grants [$];   // results owed by the block, oldest first
    int        fail_count   = 0;
    int        idle_pct     = 0;
    int        stall_pct    = 0;
    int        quiet_cycles = 0;

    // Hand-written result for the item on the bus; travels with s_item.
    bit        row_known = 1'b0;
    out_item_t row_want  = '0;

    fit_policy_block_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #1 aclk = ~aclk;

    // Apply one item to the local table and return the result it should produce.
    function automatic out_item_t place_request(input in_item_t it);
        out_item_t res;
        int        lim;
        bit        hit;
        int        pick;
        res  = '0;
        hit  = 1'b0;
        pick = 0;
        if (it.req_type == REQ_LOAD) begin
            // Loads land even on entries outside the active range.
            free_tab[it.load_index] = it.req_size;
            res.granted      = 1'b1;
            res.chosen_index = it.load_index;
            res.free_left    = it.req_size;
            return res;
        end
        // Clamp an oversized active count to the table size.
        lim = (active_cur > NUM_BLOCKS) ? NUM_BLOCKS : int'(active_cur);
        for (int j = 0; j < lim; j++) begin
            if (free_tab[j] < it.req_size)
                continue;
            if (!hit) begin
                hit  = 1'b1;
                pick = j;
                // First fit, and the spare code with it, stops at the first hit.
                if (mode_cur != FIT_BEST && mode_cur != FIT_WORST)
                    break;
            end else if (mode_cur == FIT_BEST && free_tab[j] < free_tab[pick]) begin
                pick = j;
            end else if (mode_cur == FIT_WORST && free_tab[j] > free_tab[pick]) begin
                pick = j;
            end
        end
        if (!hit)
            return res;
        free_tab[pick]   = free_tab[pick] - it.req_size;
        res.granted      = 1'b1;
        res.chosen_index = pick[LOAD_IDX_W-1:0];
        res.free_left    = free_tab[pick];
        return res;
    endfunction

    task automatic log_fault(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endtask

    // Check results against the oldest owed one, then book the item just taken.
    // Results go first: a result leaving on an edge never belongs to the item
    // accepted on that same edge.
    always @(posedge aclk) begin : watch_grants
        out_item_t want;
        out_item_t pred;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_grants.size() == 0) begin
                    log_fault($sformatf("unexpected result g=%0b idx=%0d left=%0h",
                        m_item.granted, m_item.chosen_index, m_item.free_left));
                end else begin
                    want = pending_grants.pop_front();
                    if (m_item.granted !== want.granted ||
                        m_item.chosen_index !== want.chosen_index ||
                        m_item.free_left !== want.free_left)
                        log_fault($sformatf(
                            "result mismatch: exp g=%0b idx=%0d left=%0h, got g=%0b idx=%0d left=%0h",
                            want.granted, want.chosen_index, want.free_left,
                            m_item.granted, m_item.chosen_index, m_item.free_left));
                end
            end
            if (s_valid && s_ready) begin
                pred = place_request(s_item);
                pending_grants.push_back(row_known ? row_want : pred);
            end
        end
    end

    // Receiver: stall at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one item, idling first at the phase's rate; hold it until taken.
    task automatic push_item(input in_item_t it, input bit known, input out_item_t want);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            gap++;
        end
        s_valid   <= 1'b1;
        s_item    <= it;
        row_known <= known;
        row_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait for every owed result; the extra edge lets the item
    // accepted on the last edge reach the queue first.
    task automatic drain_grants();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_grants.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write one register while the block is idle, and mirror it locally.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        if (idx == CFG_FIT_MODE)
            mode_cur = val[FIT_MODE_W-1:0];
        else
            active_cur = val[ACTIVE_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        step_row_t r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val[CFG_DATA_W-1:0];
        return r;
    endfunction

    function automatic step_row_t item_row(input logic kind, input int idx, input int size,
                                           input bit known, input logic g, input int ci,
                                           input int fl);
        step_row_t r;
        r                   = '{default: '0};
        r.item.req_type     = kind;
        r.item.load_index   = idx[LOAD_IDX_W-1:0];
        r.item.req_size     = size[REQ_SIZE_W-1:0];
        r.known             = known;
        r.want.granted      = g;
        r.want.chosen_index = ci[LOAD_IDX_W-1:0];
        r.want.free_left    = fl[REQ_SIZE_W-1:0];
        return r;
    endfunction

    // Random item: loads keep the table stocked, often with sizes from a coarse
    // grid so that ties show up; half of the requests aim at a size already in the table.
    function automatic in_item_t rand_item();
        in_item_t it;
        int       lim;
        int       pick;
        int       k;
        it  = '0;
        lim = (active_cur > NUM_BLOCKS) ? NUM_BLOCKS : int'(active_cur);
        k   = $urandom_range(9);
        if ($urandom_range(99) < 35) begin
            it.req_type   = REQ_LOAD;
            it.load_index = (lim > 0 && $urandom_range(3) != 0) ?
                            LOAD_IDX_W'($urandom_range(lim - 1)) :
                            LOAD_IDX_W'($urandom_range(NUM_BLOCKS - 1));
            case (k)
                0, 1, 2, 3: it.req_size = REQ_SIZE_W'(64 * $urandom_range(16));
                4, 5, 6:    it.req_size = REQ_SIZE_W'($urandom_range(16'hFFFF));
                7:          it.req_size = '0;
                8:          it.req_size = '1;
                default:    it.req_size = REQ_SIZE_W'($urandom_range(255));
            endcase
        end else begin
            it.req_type   = REQ_ALLOC;
            // unused by a request
            it.load_index = LOAD_IDX_W'($urandom_range(NUM_BLOCKS - 1));
            case (k)
                0, 1, 2, 3, 4: begin
                    pick        = $urandom_range(NUM_BLOCKS - 1);
                    it.req_size = free_tab[pick];
                    if ($urandom_range(1) && free_tab[pick] > 3)
                        it.req_size = REQ_SIZE_W'(free_tab[pick] - $urandom_range(3));
                end
                5:       it.req_size = '0;
                6:       it.req_size = '1;
                7, 8:    it.req_size = REQ_SIZE_W'($urandom_range(300));
                default: it.req_size = REQ_SIZE_W'($urandom_range(16'hFFFF));
            endcase
        end
        return it;
    endfunction

    initial begin
        step_row_t             plan [$];
        logic [FIT_MODE_W-1:0] phase_modes [PHASES];
        int                    phase_act [PHASES];
        logic [CFG_DATA_W-1:0] mode_word;

        phase_modes = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNUSED,
                        FIT_BEST, FIT_WORST, FIT_FIRST, FIT_WORST};
        // Cover the minimum, the maximum, no active entries and an oversized count.
        phase_act   = '{16, 1, 31, 16, 7, 0, 16, 12};

        foreach (free_tab[i])
            free_tab[i] = '0;
        mode_cur   = FIT_FIRST;
        active_cur = ACTIVE_RESET;

        // Directed part, starting from the reset state: first fit, all 16 active,
        // table all zero.
        // A zero request fits an empty entry and leaves it unchanged.
        plan.push_back(item_row(REQ_ALLOC, 0, 0, 1, 1'b1, 0, 0));
        plan.push_back(item_row(REQ_ALLOC, 0, 16'hFFFF, 1, 1'b0, 0, 0));
        plan.push_back(item_row(REQ_LOAD, 0, 16'hFFFF, 1, 1'b1, 0, 16'hFFFF));
        plan.push_back(item_row(REQ_LOAD, 15, 0, 1, 1'b1, 15, 0));
        plan.push_back(item_row(REQ_LOAD, 5, 100, 1, 1'b1, 5, 100));
        plan.push_back(item_row(REQ_LOAD, 9, 300, 1, 1'b1, 9, 300));
        plan.push_back(item_row(REQ_LOAD, 12, 200, 1, 1'b1, 12, 200));
        // Full-size request empties entry 0.
        plan.push_back(item_row(REQ_ALLOC, 0, 16'hFFFF, 1, 1'b1, 0, 0));
        plan.push_back(item_row(REQ_ALLOC, 0, 150, 0, 1'b0, 0, 0));
        plan.push_back(cfg_row(CFG_FIT_MODE, FIT_BEST));
        plan.push_back(item_row(REQ_ALLOC, 0, 120, 0, 1'b0, 0, 0));
        plan.push_back(item_row(REQ_LOAD, 3, 200, 1, 1'b1, 3, 200));
        // Worst fit with a tie between two entries: lower index wins.
        plan.push_back(cfg_row(CFG_FIT_MODE, FIT_WORST));
        plan.push_back(item_row(REQ_ALLOC, 0, 10, 0, 1'b0, 0, 0));
        plan.push_back(cfg_row(CFG_FIT_MODE, FIT_UNUSED));
        plan.push_back(item_row(REQ_ALLOC, 0, 50, 0, 1'b0, 0, 0));
        // No active entries: even a zero request is refused.
        plan.push_back(cfg_row(CFG_ACTIVE, 0));
        plan.push_back(item_row(REQ_ALLOC, 0, 0, 1, 1'b0, 0, 0));
        plan.push_back(cfg_row(CFG_ACTIVE, 31));
        plan.push_back(item_row(REQ_ALLOC, 0, 1, 0, 1'b0, 0, 0));
        // One active entry; a load to an inactive entry still lands.
        plan.push_back(cfg_row(CFG_ACTIVE, 1));
        plan.push_back(item_row(REQ_LOAD, 7, 500, 1, 1'b1, 7, 500));
        plan.push_back(item_row(REQ_ALLOC, 0, 1, 1, 1'b0, 0, 0));
        plan.push_back(cfg_row(CFG_ACTIVE, 8));
        plan.push_back(item_row(REQ_ALLOC, 0, 500, 0, 1'b0, 0, 0));
        plan.push_back(cfg_row(CFG_FIT_MODE, FIT_BEST));
        plan.push_back(cfg_row(CFG_ACTIVE, 16));
        plan.push_back(item_row(REQ_ALLOC, 0, 0, 0, 1'b0, 0, 0));

        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_grants();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_item(plan[i].item, plan[i].known, plan[i].want);
            end
        end
        drain_grants();

        // Random part: one policy, one active count and one idling and stall profile per phase.
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 57; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 7;  stall_pct = 7;  end
            endcase
            // Odd phases put junk in the unused upper bits of the policy write.
            mode_word = CFG_DATA_W'(phase_modes[p]);
            if (p % 2 == 1)
                mode_word[CFG_DATA_W-1:FIT_MODE_W] = (CFG_DATA_W-FIT_MODE_W)'($urandom);
            write_reg(CFG_FIT_MODE, mode_word);
            write_reg(CFG_ACTIVE, phase_act[p][CFG_DATA_W-1:0]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // In phases 2 and 5, hold off mid-phase until the block has handed back everything.
                if (n == PHASE_ITEMS / 2 && p % 3 == 2)
                    drain_grants();
                push_item(rand_item(), 1'b0, '0);
            end
            drain_grants();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_grants.size() != 0)
            log_fault($sformatf("%0d results never arrived", pending_grants.size()));
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
